/* design/periodic_task_tick_scheduler_unit_defines.svh */
// Assertion helpers for the periodic task tick scheduler.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_UNIT_DEFINES_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_UNIT_DEFINES_SVH

// Clocking and reset qualification shared by every check.
`define PTTS_PROP(prop) @(posedge clk) disable iff (rst) prop

// One concurrent check with a label and a message.
`define PTTS_ASSERT(label, prop, msg) \
  label: assert property (`PTTS_PROP(prop)) else $error(msg);

`endif

/* design/ptts_pkg.sv */
`default_nettype none

package ptts_pkg;

  localparam int TASK_SLOTS_DEF = 8;
  localparam int MAX_OUT = 8;
  localparam int DCW = $clog2(MAX_OUT + 1);

  localparam logic [15:0] TPS_RESET = 16'd1000;

  // A millisecond count becomes (ms * tps) / 1000. The division is done as
  // ((x >> 3) * ceil(2^36 / 125)) >> 36, exact for every 32-bit product.
  localparam int MS_PER_SEC = 1000;
  localparam int CONV_PRESHIFT = 3;
  localparam int CONV_SHIFT = 36;
  localparam logic [29:0] CONV_RECIP = 30'd549755814;

  typedef enum logic [2:0] {
    MODE_TICK,
    MODE_DISPATCH,
    MODE_ADD,
    MODE_ENABLE,
    MODE_DISABLE,
    MODE_SET_PERIOD
  } mode_t;

  typedef enum logic [1:0] {
    ERR_OK,
    ERR_FULL,
    ERR_VACANT,
    ERR_NO_TASK
  } err_t;

  typedef struct packed {
    mode_t       mode;
    logic        ok;
    logic [15:0] delay;
    logic [15:0] period;
  } cmd_t;

  typedef struct packed {
    logic           go;
    logic [DCW-1:0] n;
  } tok_t;

  typedef struct packed {
    logic ready;
    logic pend;
    logic fire;
  } cell_stat_t;

endpackage

`default_nettype wire

/* design/periodic_task_tick_scheduler_unit.sv */
// Every item runs the ms-to-tick conversion (S_MUL, S_DIV), a launch state, then a token
// that walks the row of TASK_SLOTS task cells, one cell per cycle unless the output stalls.
// A non-dispatch result is registered once the token leaves the last cell; dispatch
// results appear as the token passes each ready, enabled cell, or once at the end if
// none fires. A new item is accepted only in S_IDLE, after the previous run has ended.
// Reset (synchronous, active high) empties the table and sets the tick rate to 1000.
`default_nettype none
`include "periodic_task_tick_scheduler_unit_defines.svh"

module periodic_task_tick_scheduler_unit
  import ptts_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  mode,
  input  wire logic [2:0]  task_slot,
  input  wire logic [15:0] delay_ms,
  input  wire logic [15:0] period_ms,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       error_code,
  output logic             task_valid,
  output logic [2:0]       task_index,
  output logic [7:0]       ready_mask,
  output logic             last
);

  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam int CMPW = (CW > 3) ? CW : 3;
  localparam int MASKW = (TASK_SLOTS > 8) ? TASK_SLOTS : 8;
  localparam logic [CW-1:0] SLOTS_C = CW'(TASK_SLOTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_LAUNCH,
    S_RUN
  } state_t;

  state_t          state;
  logic [CW-1:0]   task_count;
  logic [15:0]     tps;
  cmd_t            cmd;
  logic [CW-1:0]   target;
  err_t            res_err;
  logic            res_valid;
  logic [2:0]      res_idx;

  logic [15:0]     d_ticks;
  logic [15:0]     p_ticks;

  tok_t            tok [TASK_SLOTS + 1];
  cell_stat_t      stat [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] rdy_vec;
  logic [TASK_SLOTS-1:0] pend_vec;
  logic [TASK_SLOTS-1:0] fire_vec;
  logic [TASK_SLOTS-1:0] tok_go;
  logic [MASKW-1:0]      rdy_ext;

  logic            adv;
  logic            fire_any;
  logic            fire_last;
  logic [2:0]      fire_idx;
  logic [7:0]      run_mask;
  logic            run_end;
  logic            emit;

  err_t            acc_err;
  logic            acc_ok;
  logic            acc_valid;
  logic [2:0]      acc_idx;
  logic [CW-1:0]   acc_target;
  logic [CMPW-1:0] slot_w;
  logic [CMPW-1:0] cnt_w;

  assign in_ready = (state == S_IDLE);
  assign adv      = !out_valid || out_ready;

  ptts_conv u_conv_delay (
    .clk   (clk),
    .ms    (delay_ms),
    .tps   (tps),
    .ticks (d_ticks)
  );

  ptts_conv u_conv_period (
    .clk   (clk),
    .ms    (period_ms),
    .tps   (tps),
    .ticks (p_ticks)
  );

  assign tok[0].go = (state == S_LAUNCH);
  assign tok[0].n  = '0;

  for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
    ptts_cell #(
      .TASK_SLOTS (TASK_SLOTS),
      .IDX        (g)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .adv        (adv),
      .cmd        (cmd),
      .target     (target),
      .task_count (task_count),
      .tok_in     (tok[g]),
      .tok_out    (tok[g + 1]),
      .stat       (stat[g])
    );
  end

  always_comb begin
    for (int i = 0; i < TASK_SLOTS; i++) begin
      rdy_vec[i]  = stat[i].ready;
      pend_vec[i] = stat[i].pend;
      fire_vec[i] = stat[i].fire;
      tok_go[i]   = tok[i + 1].go;
    end
    fire_idx  = '0;
    fire_last = 1'b0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      if (fire_vec[i]) begin
        fire_idx = fire_idx | 3'(i);
        if ((tok[i].n == DCW'(MAX_OUT - 1)) || !(|(pend_vec >> (i + 1)))) begin
          fire_last = 1'b1;
        end
      end
    end
  end

  assign fire_any = |fire_vec;
  assign rdy_ext  = MASKW'(rdy_vec & ~fire_vec);
  assign run_mask = rdy_ext[7:0];
  assign run_end  = (state == S_RUN) && tok[TASK_SLOTS].go;
  assign emit     = adv && (fire_any || (run_end &&
                    !((cmd.mode == MODE_DISPATCH) && (tok[TASK_SLOTS].n != '0))));

  always_comb begin
    slot_w     = CMPW'(task_slot);
    cnt_w      = CMPW'(task_count);
    acc_err    = ERR_OK;
    acc_ok     = 1'b0;
    acc_valid  = 1'b0;
    acc_idx    = '0;
    acc_target = CW'(task_slot);
    unique case (mode_t'(mode))
      MODE_ADD: begin
        if (task_count >= SLOTS_C) begin
          acc_err = ERR_FULL;
        end else begin
          acc_ok     = 1'b1;
          acc_valid  = 1'b1;
          acc_idx    = 3'(task_count);
          acc_target = task_count;
        end
      end
      MODE_ENABLE, MODE_DISABLE, MODE_SET_PERIOD: begin
        if (task_count == '0) begin
          acc_err = ERR_VACANT;
        end else if (slot_w >= cnt_w) begin
          acc_err = ERR_NO_TASK;
        end else begin
          acc_ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      task_count <= '0;
      tps        <= TPS_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tps <= cfg_wr_data;
      end
      if (emit) begin
        out_valid  <= 1'b1;
        ready_mask <= run_mask;
        if (fire_any) begin
          error_code <= ERR_OK;
          task_valid <= 1'b1;
          task_index <= fire_idx;
          last       <= fire_last;
        end else begin
          error_code <= res_err;
          task_valid <= res_valid;
          task_index <= res_idx;
          last       <= 1'b1;
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd.mode  <= mode_t'(mode);
            cmd.ok    <= acc_ok;
            target    <= acc_target;
            res_err   <= acc_err;
            res_valid <= acc_valid;
            res_idx   <= acc_idx;
            state     <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          cmd.delay  <= d_ticks;
          cmd.period <= (p_ticks == 16'd0) ? 16'd1 : p_ticks;
          state      <= S_LAUNCH;
        end
        S_LAUNCH: begin
          if (adv) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (run_end && adv) begin
            if ((cmd.mode == MODE_ADD) && cmd.ok) begin
              task_count <= task_count + CW'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PTTS_ASSERT(a_single_token, $onehot0(tok_go), "More than one token in the cell row.")
  `PTTS_ASSERT(a_single_fire, $onehot0(fire_vec), "More than one cell dispatched at once.")
  `PTTS_ASSERT(a_token_in_run, (|tok_go) |-> (state == S_RUN), "Token outside a run.")
  `PTTS_ASSERT(a_count_max, task_count <= SLOTS_C, "Task count beyond the table size.")

endmodule

`default_nettype wire

/* design/ptts_conv.sv */
`default_nettype none

module ptts_conv
  import ptts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [15:0] ms,
  input  wire logic [15:0] tps,
  output logic      [15:0] ticks
);

  localparam int SCW = 32 - CONV_PRESHIFT + 30;

  logic [31:0]    prod;
  logic [SCW-1:0] scaled;

  assign scaled = SCW'(prod[31:CONV_PRESHIFT]) * SCW'(CONV_RECIP);

  always_ff @(posedge clk) begin
    prod  <= 32'(ms) * 32'(tps);
    ticks <= scaled[CONV_SHIFT +: 16];
  end

endmodule

`default_nettype wire

/* design/ptts_cell.sv */
`default_nettype none

module ptts_cell
  import ptts_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF,
  parameter int IDX = 0
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 adv,
  input  wire cmd_t                                 cmd,
  input  wire logic [$clog2(TASK_SLOTS + 1) - 1:0]  target,
  input  wire logic [$clog2(TASK_SLOTS + 1) - 1:0]  task_count,
  input  wire tok_t                                 tok_in,
  output tok_t                                      tok_out,
  output cell_stat_t                                stat
);

  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic [15:0] delay_left;
  logic [15:0] countdown;
  logic [15:0] reload_period;
  logic        enabled;
  logic        ready;
  logic        used;
  logic        hit;
  logic        pend;
  logic        fire;

  assign used = (IDX_C < task_count);
  assign hit  = cmd.ok && (target == IDX_C);
  assign pend = used && ready && enabled;
  assign fire = tok_in.go && (cmd.mode == MODE_DISPATCH) && pend &&
                (tok_in.n < DCW'(MAX_OUT));

  assign stat.ready = ready;
  assign stat.pend  = pend;
  assign stat.fire  = fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.go <= 1'b0;
      enabled    <= 1'b0;
      ready      <= 1'b0;
    end else if (adv) begin
      tok_out.go <= tok_in.go;
      tok_out.n  <= tok_in.n + DCW'(fire);
      if (tok_in.go) begin
        unique case (cmd.mode)
          MODE_TICK: begin
            if (used) begin
              if (delay_left != 16'd0) begin
                delay_left <= delay_left - 16'd1;
              end else begin
                countdown <= countdown - 16'd1;
                if (countdown == 16'd1) begin
                  ready <= 1'b1;
                end
              end
            end
          end
          MODE_DISPATCH: begin
            if (fire) begin
              ready     <= 1'b0;
              countdown <= reload_period;
            end
          end
          MODE_ADD: begin
            if (hit) begin
              reload_period <= cmd.period;
              countdown     <= cmd.period;
              delay_left    <= cmd.delay;
              enabled       <= 1'b1;
              ready         <= 1'b0;
            end
          end
          MODE_ENABLE: begin
            if (hit) begin
              enabled <= 1'b1;
            end
          end
          MODE_DISABLE: begin
            if (hit) begin
              enabled <= 1'b0;
            end
          end
          MODE_SET_PERIOD: begin
            if (hit) begin
              reload_period <= cmd.period;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* sim/ptts_schedule_checker.sv */
`timescale 1ns / 100ps

module ptts_schedule_checker
  import ptts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [2:0]  task_slot,
  input  logic [15:0] delay_ms,
  input  logic [15:0] period_ms,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  error_code,
  input  logic        task_valid,
  input  logic [2:0]  task_index,
  input  logic [7:0]  ready_mask,
  input  logic        last,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    err_t       err;
    logic       vld;
    logic [2:0] idx;
    logic [7:0] mask;
    logic       lst;
  } sched_result_t;

  logic [15:0]   tick_rate;
  int            used_slots;
  logic [15:0]   delay_left [TASK_SLOTS_DEF];
  logic [15:0]   countdown [TASK_SLOTS_DEF];
  logic [15:0]   reload [TASK_SLOTS_DEF];
  logic [7:0]    enabled;
  logic [7:0]    ready;
  sched_result_t due_results [$];
  int            mismatch_count = 0;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic logic [15:0] to_ticks(input logic [15:0] ms);
    logic [31:0] prod;
    prod = 32'(ms) * 32'(tick_rate);
    return 16'(prod / 32'(MS_PER_SEC));
  endfunction

  task automatic clear_schedule();
    int i;
    tick_rate = TPS_RESET;
    used_slots = 0;
    for (i = 0; i < TASK_SLOTS_DEF; i++) begin
      delay_left[i] = '0;
      countdown[i] = '0;
      reload[i] = '0;
    end
    enabled = '0;
    ready = '0;
    due_results.delete();
  endtask

  task automatic predict_schedule(input logic [2:0] m, input logic [2:0] slot,
                                  input logic [15:0] dms, input logic [15:0] pms);
    sched_result_t r;
    sched_result_t batch [MAX_OUT];
    logic [15:0]   d;
    logic [15:0]   p;
    int            i;
    int            n;
    r = '{err: ERR_OK, vld: 1'b0, idx: 3'd0, mask: 8'd0, lst: 1'b1};
    n = 0;
    case (m)
      MODE_TICK: begin
        for (i = 0; i < used_slots; i++) begin
          if (delay_left[i] != 0) begin
            delay_left[i] = delay_left[i] - 16'd1;
          end else begin
            countdown[i] = countdown[i] - 16'd1;
            if (countdown[i] == 0) ready[i] = 1'b1;
          end
        end
      end
      MODE_DISPATCH: begin
        for (i = 0; i < used_slots && n < MAX_OUT; i++) begin
          if (ready[i] && enabled[i]) begin
            ready[i] = 1'b0;
            countdown[i] = reload[i];
            batch[n] = '{err: ERR_OK, vld: 1'b1, idx: i[2:0], mask: ready, lst: 1'b0};
            n++;
          end
        end
      end
      MODE_ADD: begin
        d = to_ticks(dms);
        p = to_ticks(pms);
        if (used_slots >= TASK_SLOTS_DEF) begin
          r.err = ERR_FULL;
        end else begin
          i = used_slots;
          if (p == 0) p = 16'd1;
          reload[i] = p;
          countdown[i] = p;
          delay_left[i] = d;
          enabled[i] = 1'b1;
          ready[i] = 1'b0;
          used_slots++;
          r.vld = 1'b1;
          r.idx = i[2:0];
        end
      end
      MODE_ENABLE, MODE_DISABLE, MODE_SET_PERIOD: begin
        if (used_slots == 0) begin
          r.err = ERR_VACANT;
        end else if (int'(slot) >= used_slots) begin
          r.err = ERR_NO_TASK;
        end else if (m == MODE_ENABLE) begin
          enabled[slot] = 1'b1;
        end else if (m == MODE_DISABLE) begin
          enabled[slot] = 1'b0;
        end else begin
          p = to_ticks(pms);
          if (p == 0) p = 16'd1;
          reload[slot] = p;
        end
      end
      default: begin
      end
    endcase
    if (n == 0) begin
      r.mask = ready;
      due_results.push_back(r);
    end else begin
      batch[n-1].lst = 1'b1;
      for (i = 0; i < n; i++) due_results.push_back(batch[i]);
    end
  endtask

  task automatic check_result();
    sched_result_t got;
    sched_result_t want;
    got = '{err: err_t'(error_code), vld: task_valid, idx: task_index,
            mask: ready_mask, lst: last};
    if (due_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: unexpected result err=%0d valid=%0b index=%0d mask=%02h last=%0b",
                 $time, got.err, got.vld, got.idx, got.mask, got.lst);
    end else begin
      want = due_results.pop_front();
      if (got.err != want.err || got.vld != want.vld || got.idx != want.idx ||
          got.mask != want.mask || got.lst != want.lst) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: expected err=%0d valid=%0b index=%0d mask=%02h last=%0b",
                   $time, want.err, want.vld, want.idx, want.mask, want.lst);
          $display("%0t: got      err=%0d valid=%0b index=%0d mask=%02h last=%0b",
                   $time, got.err, got.vld, got.idx, got.mask, got.lst);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_schedule();
    end else begin
      if (out_valid && out_ready) check_result();
      if (cfg_wr_en) tick_rate = cfg_wr_data;
      if (in_valid && in_ready) predict_schedule(mode, task_slot, delay_ms, period_ms);
    end
    fail_count <= mismatch_count;
    pending <= due_results.size();
  end

endmodule

/* sim/tb_periodic_task_tick_scheduler_unit.sv */
`timescale 1ns / 100ps

module tb_periodic_task_tick_scheduler_unit;
  import ptts_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  mode;
  logic [2:0]  task_slot;
  logic [15:0] delay_ms;
  logic [15:0] period_ms;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  error_code;
  logic        task_valid;
  logic [2:0]  task_index;
  logic [7:0]  ready_mask;
  logic        last;
  int          fail_count;
  int          pending;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic [15:0] tick_rate;

  periodic_task_tick_scheduler_unit #(
    .TASK_SLOTS(TASK_SLOTS_DEF)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .task_slot(task_slot),
    .delay_ms(delay_ms),
    .period_ms(period_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .error_code(error_code),
    .task_valid(task_valid),
    .task_index(task_index),
    .ready_mask(ready_mask),
    .last(last)
  );

  ptts_schedule_checker schedule_check (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .task_slot(task_slot),
    .delay_ms(delay_ms),
    .period_ms(period_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .error_code(error_code),
    .task_valid(task_valid),
    .task_index(task_index),
    .ready_mask(ready_mask),
    .last(last),
    .fail_count(fail_count),
    .pending(pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin
    #1000000;
    $display("simulation failed");
    $finish;
  end

  task automatic send_item(input logic [2:0] m, input logic [2:0] s,
                           input logic [15:0] d, input logic [15:0] p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    task_slot <= s;
    delay_ms <= d;
    period_ms <= p;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // The token may still walk the task row after the final result of an item.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TASK_SLOTS_DEF + 8) @(negedge clk);
  endtask

  task automatic write_rate(input logic [15:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    tick_rate = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly a duration of a few ticks at the current rate, sometimes any value.
  function automatic logic [15:0] pick_ms();
    logic [31:0] target;
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    if (tick_rate == 0) return 16'($urandom_range(0, 3));
    target = $urandom_range(0, 5) * MS_PER_SEC;
    return 16'(target / tick_rate);
  endfunction

  task automatic random_item();
    int          r;
    logic [2:0]  m;
    logic [15:0] d;
    logic [15:0] p;
    r = $urandom_range(0, 99);
    if (r < 45) m = MODE_TICK;
    else if (r < 65) m = MODE_DISPATCH;
    else if (r < 70) m = MODE_ADD;
    else if (r < 78) m = MODE_ENABLE;
    else if (r < 86) m = MODE_DISABLE;
    else if (r < 96) m = MODE_SET_PERIOD;
    else m = 3'($urandom_range(6, 7));
    d = pick_ms();
    p = pick_ms();
    send_item(m, 3'($urandom_range(0, 7)), d, p);
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    mode = '0;
    task_slot = '0;
    delay_ms = '0;
    period_ms = '0;
    out_ready = 1'b0;
    tick_rate = TPS_RESET;
    send_idle_pct = 17;
    recv_idle_pct = 56;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty table, unused modes, the first adds, then enables, disables, period changes, ticks and dispatches.
    send_item(MODE_TICK, 3'd0, 16'd0, 16'd0);
    send_item(MODE_DISPATCH, 3'd0, 16'd0, 16'd0);
    send_item(MODE_ENABLE, 3'd0, 16'd0, 16'd0);
    send_item(MODE_DISABLE, 3'd7, 16'd0, 16'd0);
    send_item(MODE_SET_PERIOD, 3'd3, 16'd0, 16'd5);
    send_item(3'd6, 3'd0, 16'd0, 16'd0);
    send_item(3'd7, 3'd7, 16'hffff, 16'hffff);
    send_item(MODE_ADD, 3'd0, 16'd0, 16'd0);
    send_item(MODE_ADD, 3'd0, 16'd2, 16'd3);
    send_item(MODE_ENABLE, 3'd2, 16'd0, 16'd0);
    send_item(MODE_SET_PERIOD, 3'd7, 16'd0, 16'd4);
    send_item(MODE_DISABLE, 3'd1, 16'd0, 16'd0);
    send_item(MODE_TICK, 3'd0, 16'd0, 16'd0);
    send_item(MODE_DISPATCH, 3'd0, 16'd0, 16'd0);
    send_item(MODE_TICK, 3'd0, 16'd0, 16'd0);
    send_item(MODE_TICK, 3'd0, 16'd0, 16'd0);
    send_item(MODE_TICK, 3'd0, 16'd0, 16'd0);
    send_item(MODE_DISPATCH, 3'd0, 16'd0, 16'd0);
    send_item(MODE_ENABLE, 3'd1, 16'd0, 16'd0);
    send_item(MODE_SET_PERIOD, 3'd0, 16'd0, 16'd0);
    send_item(MODE_DISPATCH, 3'd0, 16'd0, 16'd0);

    write_rate(16'd1);
    send_item(MODE_ADD, 3'd0, 16'hffff, 16'hffff);
    send_item(MODE_ADD, 3'd0, 16'd0, 16'd999);
    send_item(MODE_ADD, 3'd0, 16'd0, 16'd3000);
    send_item(MODE_ADD, 3'd0, 16'd1000, 16'd2000);

    write_rate(16'hffff);
    send_item(MODE_ADD, 3'd0, 16'd0, 16'd0);
    send_item(MODE_ADD, 3'd0, 16'd1, 16'd1);
    send_item(MODE_ADD, 3'd0, 16'd0, 16'd0);

    write_rate(TPS_RESET);
    repeat (60) random_item();

    send_idle_pct = 56;
    recv_idle_pct = 17;
    write_rate(16'd0);
    repeat (60) random_item();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_rate(16'($urandom_range(1, 65534)));
    repeat (60) random_item();

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/ptts_pkg.sv
design/ptts_conv.sv
design/ptts_cell.sv
design/periodic_task_tick_scheduler_unit.sv
sim/ptts_schedule_checker.sv
sim/tb_periodic_task_tick_scheduler_unit.sv
